// ===== rtl/chb_pkg.sv =====
// ----------------------------------------------------------------------------
// chb_pkg
// Types, codes and the default table of the host bridge configuration space.
// ----------------------------------------------------------------------------
package chb_pkg;

  localparam int ADDR_W = 8;
  localparam int DATA_W = 8;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_BMR    = 2'd2,
    ACT_RELOAD = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHIP_VARIANT = 1'd0,
    CFG_PAM2_ENABLE  = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SECOND
  } state_t;

  localparam logic [ADDR_W-1:0] OFF_COMMAND = 8'h04;
  localparam logic [ADDR_W-1:0] OFF_CMD_HI  = 8'h05;
  localparam logic [ADDR_W-1:0] OFF_STATUS  = 8'h06;
  localparam logic [ADDR_W-1:0] OFF_STS_HI  = 8'h07;
  localparam logic [ADDR_W-1:0] OFF_RO_LO   = 8'h10;
  localparam logic [ADDR_W-1:0] OFF_RO_HI   = 8'h4e;
  localparam logic [ADDR_W-1:0] OFF_BIOS    = 8'h59;
  localparam logic [ADDR_W-1:0] OFF_PAM_LO  = 8'h5a;
  localparam logic [ADDR_W-1:0] OFF_PAM2    = 8'h5b;
  localparam logic [ADDR_W-1:0] OFF_PAM_HI  = 8'h5f;

  localparam logic [19:0] BIOS_BASE = 20'hf0000;
  localparam logic [19:0] PAM_BASE  = 20'hc0000;
  localparam logic [19:0] PAM_HALF  = 20'h04000;
  localparam logic [16:0] SIZE_64K  = 17'h10000;
  localparam logic [16:0] SIZE_16K  = 17'h04000;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              reload;
    logic              variant;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } chb_mem_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        map_valid;
    logic [19:0] region_base;
    logic [16:0] region_size;
    logic        read_internal;
    logic        write_internal;
    logic        shadow_bios;
    logic        last;
  } chb_result_t;

  function automatic logic [DATA_W-1:0] chb_default(input logic variant,
                                                    input logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] v;
    v = '0;
    case (addr)
      8'h00: v = 8'h86;
      8'h01: v = 8'h80;
      8'h02: v = 8'ha3;
      8'h03: v = 8'h04;
      8'h04: v = 8'h06;
      8'h07: v = 8'h02;
      8'h08: v = variant ? 8'h10 : 8'h03;
      8'h0b: v = 8'h06;
      8'h50: v = variant ? 8'ha0 : 8'h80;
      8'h52: v = variant ? 8'h44 : 8'h40;
      8'h57: v = 8'h31;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64: v = 8'h02;
      8'h66, 8'h67: v = variant ? 8'h02 : 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/chb_req_if.sv =====
// ----------------------------------------------------------------------------
// chb_req_if
// Access request channel: one beat is one configuration access.
// ----------------------------------------------------------------------------
interface chb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] func_num;
  logic [7:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, action, func_num, reg_offset, write_data, input ready);
  modport sink   (input valid, action, func_num, reg_offset, write_data, output ready);
endinterface

// ===== rtl/chb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// chb_rsp_if
// Result channel: read data or a region map event per beat.
// ----------------------------------------------------------------------------
interface chb_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        map_valid;
  logic [19:0] region_base;
  logic [16:0] region_size;
  logic        read_internal;
  logic        write_internal;
  logic        shadow_bios;
  logic        last;

  modport source (output valid, read_data, map_valid, region_base, region_size,
                  read_internal, write_internal, shadow_bios, last, input ready);
  modport sink   (input valid, read_data, map_valid, region_base, region_size,
                  read_internal, write_internal, shadow_bios, last, output ready);
endinterface

// ===== rtl/chb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// chb_cfg_if
// Register write channel: one beat writes one control register.
// ----------------------------------------------------------------------------
interface chb_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pci_host_bridge_config_space.sv =====
// ----------------------------------------------------------------------------
// pci_host_bridge_config_space
// The result of an access is registered in ACCESS once the output is free.
// A new access is taken only in IDLE, once the last one and any second map
// event are registered; each access makes a single read-modify-write of the
// byte memory. Reset: control and state registers clear and the space reads
// as the default table of variant 0; no clearing pass is needed, since the
// per-entry valid bits clear at once.
// ----------------------------------------------------------------------------
module pci_host_bridge_config_space (
  input logic clk,
  input logic rst,
  chb_req_if.sink   req,
  chb_rsp_if.source rsp,
  chb_cfg_if.sink   cfg
);
  import chb_pkg::*;

  state_t state, state_next;

  logic       chip_variant;
  logic       pam2_enable;
  logic       shadow;

  action_t    act;
  logic [2:0] fn;
  logic [7:0] off;
  logic [7:0] wd;

  chb_result_t out_r, pend_r;
  logic        out_valid;

  chb_mem_req_t mreq;
  logic [7:0]   old_byte;

  logic        accept, out_free, done_access, done_second;
  logic        is_write, drop, is_bios, is_pam, ev_lo, ev_hi, two_ev;
  logic [7:0]  eff_off, raw_val, wval, diff;
  logic [2:0]  pam_idx;
  logic [19:0] pam_base;
  logic        shadow_next;
  chb_result_t plain_res, lo_res, hi_res, first_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_variant <= 1'b0;
      pam2_enable  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CHIP_VARIANT: chip_variant <= cfg.data;
        CFG_PAM2_ENABLE:  pam2_enable  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign accept      = req.valid && req.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign done_access = (state == ST_ACCESS) && out_free;
  assign done_second = (state == ST_SECOND) && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_ACCESS;
      ST_ACCESS: if (out_free) state_next = two_ev ? ST_SECOND : ST_IDLE;
      ST_SECOND: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready    = 1'b0;
    mreq         = '0;
    mreq.variant = chip_variant;
    mreq.wdata   = wval;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mreq.rd_en = req.valid;
        mreq.addr  = (action_t'(req.action) == ACT_BMR) ? OFF_BIOS : req.reg_offset;
      end
      ST_ACCESS: begin
        mreq.addr   = eff_off;
        mreq.wr_en  = out_free && is_write && !drop;
        mreq.reload = out_free && (act == ACT_RELOAD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action_t'(req.action);
      fn  <= req.func_num;
      off <= req.reg_offset;
      wd  <= req.write_data;
    end
  end

  chb_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (old_byte)
  );

  // Write filter and map event decode for the byte held from the accepted beat.
  assign is_write = ((act == ACT_WRITE) && (fn == 3'd0)) || (act == ACT_BMR);
  assign eff_off  = (act == ACT_BMR) ? OFF_BIOS : off;
  assign raw_val  = (act == ACT_BMR) ? 8'h00 : wd;
  assign diff     = old_byte ^ raw_val;

  always_comb begin
    drop = 1'b0;
    wval = raw_val;
    if (eff_off >= OFF_RO_LO && eff_off <= OFF_RO_HI) begin
      drop = 1'b1;
    end
    case (eff_off)
      8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0e: drop = 1'b1;
      OFF_COMMAND: wval = (raw_val & 8'h42) | 8'h04;
      OFF_CMD_HI:  wval = raw_val & 8'h01;
      OFF_STATUS:  wval = 8'h00;
      OFF_STS_HI:  wval = 8'h02;
      default: ;
    endcase
  end

  assign is_bios  = is_write && (eff_off == OFF_BIOS);
  assign is_pam   = is_write && (eff_off inside {[OFF_PAM_LO:OFF_PAM_HI]})
                    && ((eff_off != OFF_PAM2) || pam2_enable);
  assign pam_idx  = eff_off[2:0] - 3'd2;
  assign pam_base = PAM_BASE + {2'b00, pam_idx, 15'b0};
  assign ev_lo    = is_pam && (diff[3:0] != 4'h0);
  assign ev_hi    = (is_pam || is_bios) && (diff[7:4] != 4'h0);
  assign two_ev   = ev_lo && ev_hi;

  assign shadow_next = (is_bios && (diff[7:4] != 4'h0)) ? wval[4] : shadow;

  always_comb begin
    plain_res           = '0;
    plain_res.read_data = (act == ACT_READ) ? ((fn != 3'd0) ? 8'hff : old_byte) : 8'h00;

    lo_res                = '0;
    lo_res.map_valid      = 1'b1;
    lo_res.region_base    = pam_base;
    lo_res.region_size    = SIZE_16K;
    lo_res.read_internal  = wval[0];
    lo_res.write_internal = wval[1];

    hi_res                = '0;
    hi_res.map_valid      = 1'b1;
    hi_res.region_base    = is_bios ? BIOS_BASE : pam_base + PAM_HALF;
    hi_res.region_size    = is_bios ? SIZE_64K : SIZE_16K;
    hi_res.read_internal  = wval[4];
    hi_res.write_internal = wval[5];

    if (ev_lo) begin
      first_res = lo_res;
    end else if (ev_hi) begin
      first_res = hi_res;
    end else begin
      first_res = plain_res;
    end
    first_res.shadow_bios = shadow_next;
    first_res.last        = !two_ev;
    hi_res.shadow_bios    = shadow_next;
    hi_res.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow <= 1'b0;
    end else if (done_access) begin
      shadow <= shadow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_access || done_second) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_access) begin
      out_r  <= first_res;
      pend_r <= hi_res;
    end else if (done_second) begin
      out_r <= pend_r;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.read_data      = out_r.read_data;
  assign rsp.map_valid      = out_r.map_valid;
  assign rsp.region_base    = out_r.region_base;
  assign rsp.region_size    = out_r.region_size;
  assign rsp.read_internal  = out_r.read_internal;
  assign rsp.write_internal = out_r.write_internal;
  assign rsp.shadow_bios    = out_r.shadow_bios;
  assign rsp.last           = out_r.last;

endmodule

// ===== rtl/chb_store.sv =====
// ----------------------------------------------------------------------------
// chb_store
// Configuration byte memory with per-entry valid bits. An entry that has not
// been written since reset or the last reload reads as the default table.
// ----------------------------------------------------------------------------
module chb_store (
  input  logic                 clk,
  input  logic                 rst,
  input  chb_pkg::chb_mem_req_t req,
  output logic [chb_pkg::DATA_W-1:0] rdata
);
  import chb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DEPTH-1:0]  vld;
  logic              def_variant;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q  <= mem[req.addr];
      addr_q <= req.addr;
    end
  end

  // A reload only forgets what was written and picks the table variant.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      def_variant <= 1'b0;
    end else if (req.reload) begin
      vld         <= '0;
      def_variant <= req.variant;
    end else if (req.wr_en) begin
      vld[req.addr] <= 1'b1;
    end
  end

  assign rdata = vld[addr_q] ? mem_q : chb_default(def_variant, addr_q);

endmodule
